FILE: rtl/imu_scale_and_tilt_smoother_unit_macros.svh
// Assertion macros shared by the IMU scale and tilt smoother RTL.
// Depends on nothing; each use is clocked by clock and disabled in reset.
`ifndef IMU_SCALE_AND_TILT_SMOOTHER_UNIT_MACROS_SVH
`define IMU_SCALE_AND_TILT_SMOOTHER_UNIT_MACROS_SVH

// same-cycle implication
`define IMU_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IMU_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/imu_sts_pkg.sv
// Package for the IMU scale and tilt smoother: action and register codes,
// fixed constants and the CORDIC arctangent table. No dependencies.
package imu_sts_pkg;

   // action codes carried on req_tuser
   localparam logic [1:0] ACT_SAMPLE = 2'd0;
   localparam logic [1:0] ACT_FAIL   = 2'd1;
   localparam logic [1:0] ACT_RECONF = 2'd2;

   // configuration register indexes
   localparam logic REG_ALPHA = 1'b0;
   localparam logic REG_LIMIT = 1'b1;

   localparam logic [16:0] ALPHA_ONE   = 17'd65536;
   localparam logic [16:0] ALPHA_RESET = 17'd13107;
   localparam logic [7:0]  LIMIT_RESET = 8'd5;
   localparam logic [7:0]  TALLY_MAX   = 8'd255;

   // scale factors: milli-g = raw*125/2^11, mrad/s = raw*K/2^24
   localparam logic [21:0] ACCEL_K = 22'd125;
   localparam logic [21:0] GYRO_K  = 22'd2235249;

   // CORDIC datapath widths and angle format (mrad, 24 fraction bits)
   localparam int TAB_FRAC = 24;
   localparam int TAB_LEN  = 24;
   localparam int ZW       = 40;
   localparam int XW       = 44;
   localparam logic signed [ZW-1:0] PI_Q24 = 40'sd52707178533;

   // atan(2^-i) in mrad, Q24
   localparam logic signed [ZW-1:0] ATAN_TAB [TAB_LEN] = '{
      40'sd13176794633, 40'sd7778716084, 40'sd4110059947, 40'sd2086330604,
      40'sd1047213858,  40'sd524117433,  40'sd262122670,  40'sd131069333,
      40'sd65535667,    40'sd32767958,   40'sd16383995,   40'sd8191999,
      40'sd4096000,     40'sd2048000,    40'sd1024000,    40'sd512000,
      40'sd256000,      40'sd128000,     40'sd64000,      40'sd32000,
      40'sd16000,       40'sd8000,       40'sd4000,       40'sd2000
   };

   typedef struct packed {
      logic busy;
      logic done;
   } cordic_stat_type;

endpackage

FILE: rtl/imu_sts_cordic.sv
// Iterative CORDIC vectoring unit: atan2(y, x), one micro-rotation per cycle.
// Depends on imu_sts_pkg (widths, pi, arctangent table).
module imu_sts_cordic import imu_sts_pkg::*; #(
   parameter int STEPS = 16,
   parameter int FRAC  = 16,
   localparam int AW   = 14 + FRAC
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [XW-1:0] y_in,
   input  logic signed [XW-1:0] x_in,
   output logic signed [AW-1:0] angle,
   output cordic_stat_type      stat
);

   localparam int CW  = $clog2(STEPS + 1);
   localparam int RSH = TAB_FRAC - FRAC;
   localparam logic signed [ZW-1:0] RHALF = (ZW'(1) << RSH) >>> 1;

   logic signed [XW-1:0] x_ff, x_in_nxt, y_ff, y_in_nxt;
   logic signed [ZW-1:0] z_ff, z_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic signed [XW-1:0] dx, dy;
   logic signed [ZW-1:0] tab;

   // one rotation step, or the quadrant fold at start
   always_comb begin
      x_in_nxt = x_ff;
      y_in_nxt = y_ff;
      z_in     = z_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      dx       = y_ff >>> cnt_ff;
      dy       = x_ff >>> cnt_ff;
      tab      = ATAN_TAB[5'(cnt_ff)];
      if (start) begin
         cnt_in  = '0;
         busy_in = 1'b1;
         if (x_in < 0) begin
            z_in     = (y_in >= 0) ? PI_Q24 : -PI_Q24;
            x_in_nxt = -x_in;
            y_in_nxt = -y_in;
         end else begin
            z_in     = '0;
            x_in_nxt = x_in;
            y_in_nxt = y_in;
         end
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_in_nxt = x_ff + dx;
            y_in_nxt = y_ff - dy;
            z_in     = z_ff + tab;
         end else if (y_ff < 0) begin
            x_in_nxt = x_ff - dx;
            y_in_nxt = y_ff + dy;
            z_in     = z_ff - tab;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in_nxt;
      y_ff   <= y_in_nxt;
      z_ff   <= z_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // reduce to FRAC fraction bits, round half up
   assign angle     = AW'((z_ff + RHALF) >>> RSH);
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

FILE: rtl/imu_scale_and_tilt_smoother_unit.sv
// IMU scale and tilt smoother: scaling, bit-serial root, CORDIC angles, blend.
// Depends on imu_sts_pkg, imu_sts_cordic and the assertion macro header.
//
// Usage:
//   req channel: one transaction per sensor event. req_tuser is the action
//   (new sample, read failure, reconfigured), req_tdata the six raw values.
//   rsp channel: exactly one transaction per request with the held scaled
//   values, smoothed roll and pitch, failure count and link state;
//   rsp_tuser flags a fresh good sample.
//   csr port: write-only, alpha (index 0) and failure limit (index 1); to be
//   written only while the block is idle, which the block does not enforce.
// Sequence: a good sample passes through the sum, the one-bit-per-cycle
//   square root, the pitch CORDIC after it and the bit-serial alpha blend.
//   Other actions go straight to the output stage. One request is worked
//   on at a time.
// Reset: link down, tally cleared, angles zero and unprimed, held values
//   zero, registers at their defaults.
// Stall: a finished result sits in the output register; the next request
//   is accepted and processed, then waits until rsp_tready frees the slot.
`include "imu_scale_and_tilt_smoother_unit_macros.svh"
module imu_scale_and_tilt_smoother_unit import imu_sts_pkg::*; #(
   parameter int CORDIC_STEPS    = 16,
   parameter int ANGLE_FRAC_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // raw_ax, raw_ay, raw_az, raw_gx, raw_gy, raw_gz
   input  logic [95:0]   req_tdata,
   // action
   input  logic [1:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // accel_x_mg, accel_y_mg, accel_z_mg, rate_x_mrad, rate_y_mrad,
   // rate_z_mrad, roll_out, pitch_out, failure_count, link_up
   output logic [111:0]  rsp_tdata,
   // sample_valid
   output logic          rsp_tuser,
   input  logic          csr_we,
   input  logic          csr_addr,
   input  logic [16:0]   csr_wdata
);

   localparam int SW = 14 + ANGLE_FRAC_BITS;
   localparam int DW = SW + 1;
   localparam int PW = DW + 18;
   localparam logic [SW-1:0] MHALF = SW'(1) << (ANGLE_FRAC_BITS - 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SUM   = 3'd1;
   localparam logic [2:0] ST_ROOT  = 3'd2;
   localparam logic [2:0] ST_PITCH = 3'd3;
   localparam logic [2:0] ST_BLEND = 3'd4;
   localparam logic [2:0] ST_FIN   = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [16:0] alpha_ff;
   logic [7:0]  limit_ff;
   logic signed [SW-1:0] roll_s_ff, roll_s_in, pitch_s_ff, pitch_s_in;
   logic        primed_ff, primed_in, link_ff, link_in, fresh_ff, fresh_in;
   logic [7:0]  tally_ff, tally_in, tally_inc;
   logic signed [15:0] raw_ff [6];
   logic signed [11:0] accel_ff [3];
   logic signed [13:0] rate_ff [3];
   logic [31:0] sqy_ff, sqz_ff;
   logic [63:0] rem_ff, rem_in, root_ff, root_in, rbit, trial;
   logic [4:0]  rk_ff, rk_in, bk_ff, bk_in;
   logic [2:0]  scl_ff, scl_in;
   logic signed [PW-1:0] racc_ff, racc_in, pacc_ff, pacc_in;
   logic        rsp_valid_ff, rsp_load;
   logic [111:0] rsp_data_ff;
   logic        rsp_user_ff;
   logic [12:0] roll_mrad, pitch_mrad;

   logic        accept, roll_start, pitch_start;
   logic signed [15:0] ax, ay, az;
   logic signed [16:0] nax;
   logic signed [XW-1:0] roll_y, roll_x, pitch_y, pitch_x;
   logic signed [SW-1:0] roll_ang, pitch_ang;
   cordic_stat_type roll_stat, pitch_stat;
   logic [16:0] a_eff;
   logic signed [DW-1:0] rdiff, pdiff;

   // scaler
   logic signed [15:0] sraw;
   logic [16:0] smag;
   logic [38:0] sprod, sround;
   logic [13:0] smag_out;
   logic signed [13:0] sval;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign ax = $signed(req_tdata[15:0]);
   assign ay = $signed(req_tdata[31:16]);
   assign az = $signed(req_tdata[47:32]);

   // CORDIC operands: roll from (ay, az), pitch from (-ax, |ayz|)
   assign roll_start  = accept && (req_tuser == ACT_SAMPLE) && link_ff;
   assign roll_y      = XW'($signed({ay, 24'b0}));
   assign roll_x      = XW'($signed({az, 24'b0}));
   assign nax         = -(17'(raw_ff[0]));
   assign pitch_y     = XW'($signed({nax, 24'b0}));
   assign pitch_x     = XW'($signed({1'b0, root_in[31:0], 9'b0}));
   assign pitch_start = (state_ff == ST_ROOT) && (rk_ff == 5'd31);

   imu_sts_cordic #(.STEPS(CORDIC_STEPS), .FRAC(ANGLE_FRAC_BITS)) u_roll (
      .clock(clock), .reset(reset), .start(roll_start),
      .y_in(roll_y), .x_in(roll_x), .angle(roll_ang), .stat(roll_stat)
   );

   imu_sts_cordic #(.STEPS(CORDIC_STEPS), .FRAC(ANGLE_FRAC_BITS)) u_pitch (
      .clock(clock), .reset(reset), .start(pitch_start),
      .y_in(pitch_y), .x_in(pitch_x), .angle(pitch_ang), .stat(pitch_stat)
   );

   // shared scaler, one channel per cycle, rounded half away from zero
   always_comb begin
      sraw     = raw_ff[(scl_ff < 3'd6) ? scl_ff : 3'd0];
      smag     = sraw[15] ? 17'(-17'(sraw)) : 17'(sraw);
      sprod    = 39'(smag) * 39'((scl_ff < 3'd3) ? ACCEL_K : GYRO_K);
      if (scl_ff < 3'd3) begin
         sround = (sprod + 39'd1024) >> 11;
      end else begin
         sround = (sprod + 39'd8388608) >> 24;
      end
      smag_out = sround[13:0];
      sval     = sraw[15] ? -$signed(smag_out) : $signed(smag_out);
   end

   // bit-serial square root step
   always_comb begin
      rbit  = 64'(1) << (6'd62 - {rk_ff, 1'b0});
      trial = root_ff + rbit;
   end

   // blend differences
   assign a_eff = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;
   assign rdiff = DW'(roll_ang) - DW'(roll_s_ff);
   assign pdiff = DW'(pitch_ang) - DW'(pitch_s_ff);
   assign tally_inc = (tally_ff < TALLY_MAX) ? tally_ff + 8'd1 : tally_ff;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      roll_s_in  = roll_s_ff;
      pitch_s_in = pitch_s_ff;
      primed_in  = primed_ff;
      link_in    = link_ff;
      tally_in   = tally_ff;
      fresh_in   = fresh_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;
      rk_in      = rk_ff;
      bk_in      = bk_ff;
      scl_in     = scl_ff;
      racc_in    = racc_ff;
      pacc_in    = pacc_ff;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               fresh_in = 1'b0;
               scl_in   = '0;
               state_in = ST_FIN;
               case (req_tuser)
                  ACT_SAMPLE: begin
                     if (link_ff) begin
                        tally_in = '0;
                        fresh_in = 1'b1;
                        state_in = ST_SUM;
                     end
                  end
                  ACT_FAIL: begin
                     if (link_ff) begin
                        tally_in = tally_inc;
                        if (tally_inc >= limit_ff) begin
                           link_in = 1'b0;
                        end
                     end
                  end
                  ACT_RECONF: begin
                     link_in   = 1'b1;
                     tally_in  = '0;
                     primed_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_SUM: begin
            rem_in   = 64'(33'(sqy_ff) + 33'(sqz_ff)) << 30;
            root_in  = '0;
            rk_in    = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (rem_ff >= trial) begin
               rem_in  = rem_ff - trial;
               root_in = (root_ff >> 1) + rbit;
            end else begin
               root_in = root_ff >> 1;
            end
            rk_in = rk_ff + 5'd1;
            if (scl_ff < 3'd6) begin
               scl_in = scl_ff + 3'd1;
            end
            if (rk_ff == 5'd31) begin
               state_in = ST_PITCH;
            end
         end
         ST_PITCH: begin
            if (pitch_stat.done) begin
               racc_in  = '0;
               pacc_in  = '0;
               bk_in    = 5'd16;
               state_in = ST_BLEND;
            end
         end
         ST_BLEND: begin
            racc_in = (racc_ff <<< 1) + (a_eff[bk_ff] ? PW'(rdiff) : PW'(0));
            pacc_in = (pacc_ff <<< 1) + (a_eff[bk_ff] ? PW'(pdiff) : PW'(0));
            bk_in   = bk_ff - 5'd1;
            if (bk_ff == 5'd0) begin
               if (primed_ff) begin
                  roll_s_in  = roll_s_ff + SW'((racc_in + PW'(32768)) >>> 16);
                  pitch_s_in = pitch_s_ff + SW'((pacc_in + PW'(32768)) >>> 16);
               end else begin
                  roll_s_in  = roll_ang;
                  pitch_s_in = pitch_ang;
               end
               primed_in = 1'b1;
               state_in  = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // smoothed angle to mrad, rounded half away from zero
   function automatic logic [12:0] to_mrad(input logic signed [SW-1:0] v);
      logic [SW-1:0] m;
      logic [SW-1:0] r;
      m = v[SW-1] ? SW'(-v) : SW'(v);
      r = (m + MHALF) >> ANGLE_FRAC_BITS;
      return v[SW-1] ? 13'(-r) : 13'(r);
   endfunction

   assign roll_mrad  = to_mrad(roll_s_ff);
   assign pitch_mrad = to_mrad(pitch_s_ff);

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
      rk_ff   <= rk_in;
      bk_ff   <= bk_in;
      scl_ff  <= scl_in;
      racc_ff <= racc_in;
      pacc_ff <= pacc_in;
      if (accept) begin
         raw_ff[0] <= ax;
         raw_ff[1] <= ay;
         raw_ff[2] <= az;
         raw_ff[3] <= $signed(req_tdata[63:48]);
         raw_ff[4] <= $signed(req_tdata[79:64]);
         raw_ff[5] <= $signed(req_tdata[95:80]);
         sqy_ff    <= 32'(ay * ay);
         sqz_ff    <= 32'(az * az);
      end
      if (rsp_load) begin
         rsp_data_ff <= {link_ff, tally_ff, pitch_mrad[11:0],
                         roll_mrad, rate_ff[2], rate_ff[1], rate_ff[0],
                         accel_ff[2], accel_ff[1], accel_ff[0]};
         rsp_user_ff <= fresh_ff;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         alpha_ff     <= ALPHA_RESET;
         limit_ff     <= LIMIT_RESET;
         roll_s_ff    <= '0;
         pitch_s_ff   <= '0;
         primed_ff    <= 1'b0;
         link_ff      <= 1'b0;
         tally_ff     <= '0;
         fresh_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            accel_ff[i] <= '0;
            rate_ff[i]  <= '0;
         end
      end else begin
         state_ff   <= state_in;
         roll_s_ff  <= roll_s_in;
         pitch_s_ff <= pitch_s_in;
         primed_ff  <= primed_in;
         link_ff    <= link_in;
         tally_ff   <= tally_in;
         fresh_ff   <= fresh_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_ROOT && scl_ff < 3'd6) begin
            if (scl_ff < 3'd3) begin
               accel_ff[scl_ff[1:0]] <= sval[11:0];
            end else begin
               rate_ff[2'(scl_ff - 3'd3)] <= sval;
            end
         end
         if (csr_we) begin
            case (csr_addr)
               REG_ALPHA: alpha_ff <= csr_wdata;
               REG_LIMIT: limit_ff <= csr_wdata[7:0];
               default: ;
            endcase
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `IMU_ASSERT_IMP(a_fresh_link, rsp_tvalid && rsp_tuser, rsp_tdata[111], "fresh sample with link down")
   `IMU_ASSERT_IMP(a_fresh_tally, rsp_tvalid && rsp_tuser, rsp_tdata[110:103] == 8'd0, "tally not cleared by good sample")
   `IMU_ASSERT_NXT(a_reconf, accept && req_tuser == ACT_RECONF, link_ff && tally_ff == 8'd0 && !primed_ff, "reconfiguration not applied")
   `IMU_ASSERT_NXT(a_one_item, accept, !req_tready, "second transaction taken while busy")
   `IMU_ASSERT_IMP(a_roll_idle, state_ff == ST_BLEND, !roll_stat.busy, "roll angle not ready for blend")

endmodule
